@@ rtl/core/sjnq_pkg.sv @@
package sjnq_pkg;

   // One queue entry as it is kept in the store.
   typedef struct packed {
      logic [15:0] pages;
      logic [15:0] id;
   } entry_type;

   // Operation codes on req_func.
   localparam logic FUNC_ENQ = 1'b0;
   localparam logic FUNC_DEQ = 1'b1;

   // Result status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // Id handed out first after reset and after a wrap.
   localparam logic [15:0] FIRST_ID = 16'd1;
   localparam logic [15:0] LAST_ID  = 16'hFFFF;

endpackage

@@ rtl/core/shortest_job_next_queue_core.sv @@
// Shortest-job-next queue: holds up to DEPTH jobs ordered by ascending page
// count, oldest first among equal counts.
// Command channel: drive req_func and req_job_pages with start high; the beat
// is taken at the rising edge where start is high and busy is low.
// req_func selects enqueue (job gets the next id, 1 upwards, wrapping past
// 65535 back to 1) or dequeue (front job removed, its id returned).
// Result channel: rsp_valid is high for exactly one cycle per command and
// carries status, id, count after the operation and the empty flag. The
// receiver cannot stall, so a result beat must be taken when it appears.
// Timing: errors and an enqueue into an empty queue answer in the cycle after
// the command. A dequeue reads the front entry and answers from the read data.
// An enqueue walks from the tail, one held entry per cycle through the single
// read port of the entry memory, moving each held job with a larger page count
// one place back before the new job is written. busy stays high throughout.
// Reset (synchronous) empties the queue and sets the next id to 1; the
// entry memory itself is not cleared, as only held entries are ever read.
module shortest_job_next_queue_core #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [15:0] req_job_pages,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_job_id,
   output logic [4:0]  rsp_job_count,
   output logic        rsp_queue_empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   sjnq_pkg::entry_type wr_data;
   logic                rd_en;
   logic [AW-1:0]       rd_addr;
   sjnq_pkg::entry_type rd_data;

   // Entry memory in circular order from the head pointer.
   sjnq_store #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Command sequencer, counters and result register.
   sjnq_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_job_pages   (req_job_pages),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_job_id      (rsp_job_id),
      .rsp_job_count   (rsp_job_count),
      .rsp_queue_empty (rsp_queue_empty),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_en           (rd_en),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data)
   );

endmodule

@@ rtl/core/sjnq_store.sv @@
module sjnq_store #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  sjnq_pkg::entry_type   wr_data,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output sjnq_pkg::entry_type   rd_data
);

   sjnq_pkg::entry_type mem [DEPTH];
   sjnq_pkg::entry_type rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Single read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/sjnq_ctrl.sv @@
module sjnq_ctrl #(
   parameter int DEPTH = 16,
   parameter int AW    = 4,
   parameter int CW    = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_func,
   input  logic [15:0]           req_job_pages,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_status,
   output logic [15:0]           rsp_job_id,
   output logic [4:0]            rsp_job_count,
   output logic                  rsp_queue_empty,
   output logic                  wr_en,
   output logic [AW-1:0]         wr_addr,
   output sjnq_pkg::entry_type   wr_data,
   output logic                  rd_en,
   output logic [AW-1:0]         rd_addr,
   input  sjnq_pkg::entry_type   rd_data
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_WALK  = 4'b0010,
      ST_PLACE = 4'b0100,
      ST_DEQ   = 4'b1000
   } state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   count_ff, count_in;
   logic [AW-1:0]   head_ff, head_in;
   logic [AW-1:0]   pos_ff, pos_in;
   logic [15:0]     pages_ff, pages_in;
   logic [15:0]     id_ff, id_in;
   logic [15:0]     next_id_ff, next_id_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;
   logic [15:0]     rsp_id_ff, rsp_id_in;
   logic [CW+4:0]   count_wide;
   logic            accept;
   logic            is_full;
   logic [AW-1:0]   tail_pos;
   logic [15:0]     next_id_step;

   // Position in queue order to physical slot; both operands stay below DEPTH.
   function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                          input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   assign accept       = start && (state_ff == ST_IDLE);
   assign is_full      = (count_ff == CW'(DEPTH));
   assign tail_pos     = AW'(count_ff - CW'(1));
   assign next_id_step = (next_id_ff == sjnq_pkg::LAST_ID) ? sjnq_pkg::FIRST_ID
                                                           : next_id_ff + 16'd1;

   // Sequencer: insertion walks from the tail towards the front, one entry a cycle.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      pos_in        = pos_ff;
      pages_in      = pages_ff;
      id_in         = id_ff;
      next_id_in    = next_id_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      wr_en         = 1'b0;
      wr_addr       = head_ff;
      wr_data       = '{pages: pages_ff, id: id_ff};
      rd_en         = 1'b0;
      rd_addr       = head_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == sjnq_pkg::FUNC_ENQ) begin
                  if (is_full) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = sjnq_pkg::STATUS_FULL;
                     rsp_id_in     = '0;
                  end else if (count_ff == '0) begin
                     wr_en         = 1'b1;
                     wr_addr       = head_ff;
                     wr_data       = '{pages: req_job_pages, id: next_id_ff};
                     count_in      = CW'(1);
                     next_id_in    = next_id_step;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = sjnq_pkg::STATUS_OK;
                     rsp_id_in     = next_id_ff;
                  end else begin
                     pages_in   = req_job_pages;
                     id_in      = next_id_ff;
                     next_id_in = next_id_step;
                     pos_in     = tail_pos;
                     rd_en      = 1'b1;
                     rd_addr    = slot(head_ff, tail_pos);
                     state_in   = ST_WALK;
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = sjnq_pkg::STATUS_EMPTY;
                     rsp_id_in     = '0;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = head_ff;
                     state_in = ST_DEQ;
                  end
               end
            end
         end

         ST_WALK: begin
            wr_en   = 1'b1;
            wr_addr = slot(head_ff, pos_ff + AW'(1));
            if (rd_data.pages > pages_ff) begin
               // Larger key moves one place back; walk on, or place at the front after position zero.
               wr_data = rd_data;
               if (pos_ff == '0) begin
                  state_in = ST_PLACE;
               end else begin
                  pos_in  = pos_ff - AW'(1);
                  rd_en   = 1'b1;
                  rd_addr = slot(head_ff, pos_ff - AW'(1));
               end
            end else begin
               // Key not greater: the new job goes right behind it.
               count_in      = count_ff + CW'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = sjnq_pkg::STATUS_OK;
               rsp_id_in     = id_ff;
               state_in      = ST_IDLE;
            end
         end

         ST_PLACE: begin
            wr_en         = 1'b1;
            wr_addr       = head_ff;
            count_in      = count_ff + CW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = sjnq_pkg::STATUS_OK;
            rsp_id_in     = id_ff;
            state_in      = ST_IDLE;
         end

         ST_DEQ: begin
            head_in       = slot(head_ff, AW'(1));
            count_in      = count_ff - CW'(1);
            rsp_valid_in  = 1'b1;
            rsp_status_in = sjnq_pkg::STATUS_OK;
            rsp_id_in     = rd_data.id;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         next_id_ff   <= sjnq_pkg::FIRST_ID;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         next_id_ff   <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      pages_ff      <= pages_in;
      id_ff         <= id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
   end

   // The count reported is the held count after the operation.
   assign count_wide      = {5'd0, count_ff};
   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_job_id      = rsp_id_ff;
   assign rsp_job_count   = count_wide[4:0];
   assign rsp_queue_empty = (count_ff == '0);

   // The queue never holds more than DEPTH jobs.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("held count above depth");

   // A walk only visits positions of held jobs, and never starts on a full queue.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> ((CW'(pos_ff) < count_ff) && !is_full))
      else $error("walk position out of range");

   // Id zero is reserved for errors and is never handed out.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == sjnq_pkg::STATUS_OK)) |-> (rsp_job_id != 16'd0))
      else $error("successful beat carries id zero");

   // The store is only written while an accepted item is being worked on.
   assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (busy || accept))
      else $error("store written while idle");

   // Every finished operation returns the sequencer to idle in the same cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(busy && (state_in != ST_IDLE)))
      else $error("result beat while work continues");

endmodule
